// ===== hdl/kgc_pkg.sv =====
// Package for the key gesture classifier: field widths, reset values of the
// configuration registers, gesture and register codes and the transaction structs.
// Depends on nothing; every other file of the block imports it.
package kgc_pkg;

   // Field widths fixed by the transaction format.
   localparam int KEY_W   = 4;
   localparam int PIN_W   = 9;
   localparam int TIME_W  = 16;
   localparam int CNT_W   = 8;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 3;

   // Default key count and configuration reset values.
   localparam int NUM_KEYS_DEF = 9;
   localparam logic [TIME_W-1:0] DEF_DEBOUNCE = 16'd10;
   localparam logic [TIME_W-1:0] DEF_LONG     = 16'd1000;
   localparam logic [TIME_W-1:0] DEF_REPEAT   = 16'd200;
   localparam logic [TIME_W-1:0] DEF_DOUBLE   = 16'd300;
   localparam logic [KEY_W-1:0]  DEF_MULTI    = 4'd4;

   // Release count from which a multi-key gesture is a double click.
   localparam logic [CNT_W-1:0] DOUBLE_MIN = 8'd2;

   // Input commands.
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_EDGE = 1'b1;

   typedef enum logic [1:0] {
      G_CLICK   = 2'd0,
      G_DOUBLE  = 2'd1,
      G_LONG    = 2'd2,
      G_RELEASE = 2'd3
   } gesture_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE = 3'd0,
      CSR_LONG     = 3'd1,
      CSR_REPEAT   = 3'd2,
      CSR_DOUBLE   = 3'd3,
      CSR_MULTI    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic             cmd;
      logic [KEY_W-1:0] key;
      logic [PIN_W-1:0] pins;
   } req_type;

   typedef struct packed {
      gesture_type      gesture;
      logic [KEY_W-1:0] key_index;
      logic [CNT_W-1:0] press_count;
      logic             last;
   } rsp_type;

   // Configuration registers as seen by the classifier engine.
   typedef struct packed {
      logic [TIME_W-1:0] debounce_ms;
      logic [TIME_W-1:0] long_ms;
      logic [TIME_W-1:0] repeat_ms;
      logic [TIME_W-1:0] double_ms;
      logic [KEY_W-1:0]  multi_key;
   } cfg_type;

   // Up to two results produced by one input transaction.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } pair_type;

endpackage

// ===== hdl/kgc_engine.sv =====
// Classifier engine: holds the timers, the active key and the release counters,
// and turns one input transaction into zero, one or two results in a single pass.
// Depends on kgc_pkg.
module kgc_engine #(
   parameter int NUM_KEYS = kgc_pkg::NUM_KEYS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  kgc_pkg::req_type   item,
   input  kgc_pkg::cfg_type   cfg,
   output kgc_pkg::pair_type  results
);
   import kgc_pkg::*;

   logic [KEY_W-1:0]  active_key_ff,  active_key_in;
   logic [TIME_W-1:0] main_left_ff,   main_left_in;
   logic              main_armed_ff,  main_armed_in;
   logic [TIME_W-1:0] long_left_ff,   long_left_in;
   logic              long_flag_ff,   long_flag_in;
   logic [TIME_W-1:0] click_left_ff,  click_left_in;
   logic              click_armed_ff, click_armed_in;
   logic [KEY_W-1:0]  click_key_ff,   click_key_in;
   logic [CNT_W-1:0]  counts_ff [NUM_KEYS];
   logic [CNT_W-1:0]  counts_in [NUM_KEYS];

   logic [KEY_W-1:0] click_sel;
   logic [CNT_W-1:0] click_cnt;
   logic             click_fire;
   logic             main_fire;
   logic             pressed;
   logic             count_clear;
   logic             count_inc;
   logic             click_emit;
   logic             main_emit;
   rsp_type          click_res;
   rsp_type          main_res;

   // Release counter of the click window key, selected by compare per entry.
   always_comb begin
      click_sel = (32'(click_key_ff) < NUM_KEYS) ? click_key_ff : '0;
      click_cnt = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (int'(click_sel) == i) begin
            click_cnt = counts_ff[i];
         end
      end
   end

   // Next state and results for the transaction in the input register.
   always_comb begin
      active_key_in  = active_key_ff;
      main_left_in   = main_left_ff;
      main_armed_in  = main_armed_ff;
      long_left_in   = long_left_ff;
      long_flag_in   = long_flag_ff;
      click_left_in  = click_left_ff;
      click_armed_in = click_armed_ff;
      click_key_in   = click_key_ff;
      click_fire     = 1'b0;
      main_fire      = 1'b0;
      pressed        = 1'b0;
      count_clear    = 1'b0;
      count_inc      = 1'b0;
      click_emit     = 1'b0;
      main_emit      = 1'b0;
      click_res      = '0;
      main_res       = '0;

      if (item.cmd == CMD_EDGE) begin
         // An edge on a known key restarts both countdowns.
         if (32'(item.key) < NUM_KEYS) begin
            active_key_in = item.key;
            long_left_in  = cfg.long_ms;
            main_left_in  = cfg.debounce_ms;
            main_armed_in = 1'b1;
         end
      end else begin
         // The long countdown saturates at zero.
         if (long_left_ff != '0) begin
            long_left_in = long_left_ff - 1'b1;
         end

         // Double-click window: report the collected count when it runs out.
         if (click_armed_ff) begin
            click_fire    = (click_left_ff <= TIME_W'(1));
            click_left_in = click_fire ? '0 : click_left_ff - 1'b1;
         end
         if (click_fire) begin
            click_emit            = 1'b1;
            click_res.gesture     = (click_cnt < DOUBLE_MIN) ? G_CLICK : G_DOUBLE;
            click_res.key_index   = click_sel;
            click_res.press_count = click_cnt;
            count_clear           = 1'b1;
            click_armed_in        = 1'b0;
         end

         // Debounce and repeat timer: sample the active pin when it runs out.
         if (main_armed_ff) begin
            main_fire    = (main_left_ff <= TIME_W'(1));
            main_left_in = main_fire ? '0 : main_left_ff - 1'b1;
         end
         if (main_fire) begin
            main_armed_in = 1'b0;
            if (32'(active_key_ff) < PIN_W) begin
               pressed = ~item.pins[active_key_ff];
            end
            main_res.key_index = active_key_ff;
            if (pressed) begin
               main_left_in  = cfg.repeat_ms;
               main_armed_in = 1'b1;
               if (long_left_in != '0) begin
                  if (active_key_ff != cfg.multi_key) begin
                     main_emit        = 1'b1;
                     main_res.gesture = G_CLICK;
                  end
               end else begin
                  main_emit        = 1'b1;
                  main_res.gesture = G_LONG;
                  long_flag_in     = 1'b1;
               end
            end else if (active_key_ff == cfg.multi_key && !long_flag_ff &&
                         32'(active_key_ff) < NUM_KEYS) begin
               click_key_in   = active_key_ff;
               count_inc      = 1'b1;
               click_left_in  = cfg.double_ms;
               click_armed_in = 1'b1;
            end else begin
               main_emit        = 1'b1;
               main_res.gesture = G_RELEASE;
               long_flag_in     = 1'b0;
            end
         end
      end

      // Each counter updates on its own: clear after a report, then count a release.
      for (int i = 0; i < NUM_KEYS; i++) begin
         counts_in[i] = counts_ff[i];
         if (count_clear && int'(click_sel) == i) begin
            counts_in[i] = '0;
         end
         if (count_inc && int'(active_key_ff) == i) begin
            counts_in[i] = counts_in[i] + 1'b1;
         end
      end
   end

   // Results in order: window report first, then the sample of the active pin.
   always_comb begin
      results = '0;
      if (click_emit) begin
         results.first       = click_res;
         results.first.last  = ~main_emit;
         results.second      = main_res;
         results.second.last = 1'b1;
         results.count       = main_emit ? 2'd2 : 2'd1;
      end else if (main_emit) begin
         results.first      = main_res;
         results.first.last = 1'b1;
         results.count      = 2'd1;
      end
   end

   // State registers advance once per processed transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_key_ff  <= '0;
         main_left_ff   <= '0;
         main_armed_ff  <= 1'b0;
         long_left_ff   <= '0;
         long_flag_ff   <= 1'b0;
         click_left_ff  <= '0;
         click_armed_ff <= 1'b0;
         click_key_ff   <= '0;
         for (int i = 0; i < NUM_KEYS; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (step) begin
         active_key_ff  <= active_key_in;
         main_left_ff   <= main_left_in;
         main_armed_ff  <= main_armed_in;
         long_left_ff   <= long_left_in;
         long_flag_ff   <= long_flag_in;
         click_left_ff  <= click_left_in;
         click_armed_ff <= click_armed_in;
         click_key_ff   <= click_key_in;
         for (int i = 0; i < NUM_KEYS; i++) begin
            counts_ff[i] <= counts_in[i];
         end
      end
   end

endmodule

// ===== hdl/kgc_rsp_buf.sv =====
// Result register of the key gesture classifier: holds the up to two results of
// one transaction and hands them out one per cycle on rsp unless rsp is stalled.
// Depends on kgc_pkg.
module kgc_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  kgc_pkg::pair_type results,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output kgc_pkg::rsp_type  rsp_data,
   output logic              free
);
   import kgc_pkg::*;

   logic [1:0] left_ff, left_in;
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic       take;

   assign rsp_valid = (left_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   assign take      = rsp_valid && !rsp_stall;

   // Room for a new transaction once the last pending result leaves.
   assign free = (left_ff == 2'd0) || (left_ff == 2'd1 && take);

   // Load a new pair, or shift the second result forward after a transaction.
   always_comb begin
      left_in  = left_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         left_in  = results.count;
         slot0_in = results.first;
         slot1_in = results.second;
      end else if (take) begin
         left_in  = left_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 2'd0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// ===== hdl/key_gesture_classifier.sv =====
// Key gesture classifier: each input transaction is a millisecond tick with the pin
// levels or an edge event on a key. An edge starts debounce and long-press timing for
// its key; ticks run the timers and report click, double click (multi key only), long
// press and release. A transaction is taken into the input register and processed into
// the result register, which drives rsp; one transaction per cycle is sustained while
// rsp is not stalled. A tick that gives two results holds the result register for two
// output transactions, since rsp carries one result per cycle. Configuration writes
// are taken at any time and apply from the next processed transaction.
module key_gesture_classifier #(
   parameter int NUM_KEYS = kgc_pkg::NUM_KEYS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  kgc_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output kgc_pkg::rsp_type       rsp_data,
   input  logic                   csr_write_en,
   input  kgc_pkg::csr_index_type csr_index,
   input  logic [kgc_pkg::CSR_W-1:0] csr_wdata
);
   import kgc_pkg::*;

   logic     in_valid_ff, in_valid_in;
   req_type  in_data_ff;
   cfg_type  cfg_ff;
   pair_type results;
   logic     free;
   logic     advance;

   // The input register moves on when the result register has room.
   assign advance   = in_valid_ff && free;
   assign req_stall = in_valid_ff && !free;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Configuration registers, written by index.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms <= DEF_DEBOUNCE;
         cfg_ff.long_ms     <= DEF_LONG;
         cfg_ff.repeat_ms   <= DEF_REPEAT;
         cfg_ff.double_ms   <= DEF_DOUBLE;
         cfg_ff.multi_key   <= DEF_MULTI;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE: cfg_ff.debounce_ms <= csr_wdata;
            CSR_LONG:     cfg_ff.long_ms     <= csr_wdata;
            CSR_REPEAT:   cfg_ff.repeat_ms   <= csr_wdata;
            CSR_DOUBLE:   cfg_ff.double_ms   <= csr_wdata;
            CSR_MULTI:    cfg_ff.multi_key   <= csr_wdata[KEY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   kgc_engine #(
      .NUM_KEYS(NUM_KEYS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (in_data_ff),
      .cfg     (cfg_ff),
      .results (results)
   );

   kgc_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .results   (results),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .free      (free)
   );

   // An edge event never produces a result.
   a_edge_silent: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.cmd == CMD_EDGE |=> !rsp_valid)
      else $error("edge event produced a result");

   // A result that is not the last one is followed directly by the last one.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last && !rsp_stall |=> rsp_valid && rsp_data.last)
      else $error("first of two results not followed by the final result");

   // A held input transaction stays in the input register untouched.
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff && $stable(in_data_ff))
      else $error("held input transaction was lost or changed");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for key_gesture_classifier: a table of directed transactions,
// then random press sequences under several register settings. It depends only on
// kgc_pkg and the key_gesture_classifier RTL.
module tb;
   import kgc_pkg::*;

   localparam int PERIOD_NS = 12;
   localparam int KEYS = NUM_KEYS_DEF;
   localparam int SETTLE_CYCLES = 8;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam logic [KEY_W-1:0] WRAP_KEY = 4'd7;
   localparam rsp_type NO_RESULT = '0;

   // One row of the directed table; the typed expectation is used only when typed is set.
   typedef struct packed {
      req_type    item;
      logic       typed;
      logic [1:0] n_rsp;
      rsp_type    first;
      rsp_type    second;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_write_en = 1'b0;
   csr_index_type     csr_index = CSR_DEBOUNCE;
   logic [CSR_W-1:0]  csr_wdata = '0;

   // Shadow of the classifier: register copies and timer state.
   logic [TIME_W-1:0] debounce_cfg = DEF_DEBOUNCE;
   logic [TIME_W-1:0] long_cfg = DEF_LONG;
   logic [TIME_W-1:0] repeat_cfg = DEF_REPEAT;
   logic [TIME_W-1:0] double_cfg = DEF_DOUBLE;
   logic [KEY_W-1:0]  multi_cfg = DEF_MULTI;
   logic [KEY_W-1:0]  held_key = '0;
   logic [TIME_W-1:0] sample_left = '0;
   logic              sample_armed = 1'b0;
   logic [TIME_W-1:0] long_left = '0;
   logic              long_reported = 1'b0;
   logic [TIME_W-1:0] window_left = '0;
   logic              window_open = 1'b0;
   logic [KEY_W-1:0]  window_key = '0;
   logic [CNT_W-1:0]  release_tally [KEYS] = '{default: '0};

   rsp_type gestures_due [$];
   int      fail_count = 0;
   bit      calm = 1'b0;

   key_gesture_classifier uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #(PERIOD_NS / 2) clock = ~clock;

   function automatic rsp_type make_gesture(gesture_type g, logic [KEY_W-1:0] k,
                                            logic [CNT_W-1:0] cnt, logic fin);
      rsp_type r;
      r.gesture = g;
      r.key_index = k;
      r.press_count = cnt;
      r.last = fin;
      return r;
   endfunction

   function automatic req_type key_tick(logic [PIN_W-1:0] pins);
      req_type r;
      r.cmd = CMD_TICK;
      r.key = '0;
      r.pins = pins;
      return r;
   endfunction

   function automatic req_type key_edge(logic [KEY_W-1:0] k, logic [PIN_W-1:0] pins);
      req_type r;
      r.cmd = CMD_EDGE;
      r.key = k;
      r.pins = pins;
      return r;
   endfunction

   // A tick with random pins and a random ignored key, but with the pin of key k forced.
   function automatic req_type held_tick(logic [KEY_W-1:0] k, logic level);
      req_type r;
      r.cmd = CMD_TICK;
      r.key = KEY_W'($urandom_range(0, 15));
      r.pins = PIN_W'($urandom_range(0, 511));
      if (k < PIN_W) r.pins[k] = level;
      return r;
   endfunction

   // Mostly no pause; some short ones and a few long ones.
   function automatic int pause_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // Advance the shadow state by one transaction and return the gestures it causes.
   task automatic classify_press(input req_type item, output int n,
                                 output rsp_type first, output rsp_type second);
      rsp_type          found [2];
      logic [KEY_W-1:0] k;
      logic [CNT_W-1:0] cnt;
      gesture_type      g;
      logic             pressed;
      n = 0;
      found[0] = NO_RESULT;
      found[1] = NO_RESULT;
      if (item.cmd == CMD_EDGE) begin
         // Edges on keys that do not exist are dropped.
         if (item.key < KEYS) begin
            held_key = item.key;
            long_left = long_cfg;
            sample_left = debounce_cfg;
            sample_armed = 1'b1;
         end
      end else begin
         if (long_left != 0) long_left = long_left - 1'b1;
         // The double-click window is served before the sampling timer.
         if (window_open) begin
            if (window_left <= 1) begin
               window_left = '0;
               window_open = 1'b0;
               cnt = release_tally[window_key];
               if (cnt < DOUBLE_MIN) g = G_CLICK;
               else g = G_DOUBLE;
               found[n] = make_gesture(g, window_key, cnt, 1'b0);
               n++;
               release_tally[window_key] = '0;
            end else begin
               window_left = window_left - 1'b1;
            end
         end
         if (sample_armed) begin
            if (sample_left <= 1) begin
               sample_left = '0;
               sample_armed = 1'b0;
               k = held_key;
               pressed = (k < PIN_W) && (item.pins[k] == 1'b0);
               if (pressed) begin
                  sample_left = repeat_cfg;
                  sample_armed = 1'b1;
                  if (long_left != 0) begin
                     if (k != multi_cfg) begin
                        found[n] = make_gesture(G_CLICK, k, '0, 1'b0);
                        n++;
                     end
                  end else begin
                     found[n] = make_gesture(G_LONG, k, '0, 1'b0);
                     n++;
                     long_reported = 1'b1;
                  end
               end else if (k == multi_cfg && !long_reported && k < KEYS) begin
                  // The multi key collects releases until its window runs out.
                  window_key = k;
                  release_tally[k] = release_tally[k] + 1'b1;
                  window_left = double_cfg;
                  window_open = 1'b1;
               end else begin
                  found[n] = make_gesture(G_RELEASE, k, '0, 1'b0);
                  n++;
                  long_reported = 1'b0;
               end
            end else begin
               sample_left = sample_left - 1'b1;
            end
         end
      end
      if (n > 0) found[n - 1].last = 1'b1;
      first = found[0];
      second = found[1];
   endtask

   // Send one input transaction after a random pause and queue the gestures it should cause.
   task automatic feed(input req_type item, input bit typed = 1'b0, input int n_typed = 0,
                       input rsp_type first_typed = '0, input rsp_type second_typed = '0);
      int      gap;
      int      n;
      rsp_type first;
      rsp_type second;
      gap = calm ? 0 : pause_len();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      classify_press(item, n, first, second);
      if (typed) begin
         n = n_typed;
         first = first_typed;
         second = second_typed;
      end
      if (n > 0) gestures_due.push_back(first);
      if (n > 1) gestures_due.push_back(second);
   endtask

   // Hold the sender until every expected gesture has come out, then let the pipe settle.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (gestures_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_DEBOUNCE: debounce_cfg = value;
         CSR_LONG:     long_cfg = value;
         CSR_REPEAT:   repeat_cfg = value;
         CSR_DOUBLE:   double_cfg = value;
         CSR_MULTI:    multi_cfg = value[KEY_W-1:0];
         default:      ;
      endcase
   endtask

   task automatic apply_settings(input logic [CSR_W-1:0] debounce, input logic [CSR_W-1:0] hold,
                                 input logic [CSR_W-1:0] resample, input logic [CSR_W-1:0] window,
                                 input logic [CSR_W-1:0] multi_word);
      write_reg(CSR_DEBOUNCE, debounce);
      write_reg(CSR_LONG, hold);
      write_reg(CSR_REPEAT, resample);
      write_reg(CSR_DOUBLE, window);
      write_reg(CSR_MULTI, multi_word);
   endtask

   // One press sequence: an edge, the pin held for a while with some contact bounce,
   // then released. The multi key sometimes gets a few quick presses in a row.
   // The number of transactions sent is handed back.
   task automatic gesture_burst(output int fed);
      logic [KEY_W-1:0] k;
      int               pick;
      int               presses;
      int               hold;
      int               lift;
      fed = 0;
      pick = $urandom_range(0, 99);
      if (pick < 40 && multi_cfg < KEYS) k = multi_cfg;
      else if (pick < 90) k = KEY_W'($urandom_range(0, KEYS - 1));
      else k = KEY_W'($urandom_range(KEYS, 15));
      presses = (k == multi_cfg) ? $urandom_range(1, 3) : 1;
      for (int p = 0; p < presses; p++) begin
         feed(key_edge(k, PIN_W'($urandom_range(0, 511))));
         fed++;
         hold = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
         for (int i = 0; i < hold; i++) begin
            feed(held_tick(k, 1'b0));
            fed++;
            if ($urandom_range(0, 19) == 0) begin
               feed(key_edge(k, PIN_W'($urandom_range(0, 511))));
               fed++;
            end
         end
         lift = (p == presses - 1) ? $urandom_range(1, 10) : $urandom_range(1, 3);
         for (int i = 0; i < lift; i++) begin
            feed(held_tick(k, 1'b1));
            fed++;
         end
      end
   endtask

   // Random traffic under the current settings: mostly press sequences, some noise,
   // and now and then a full stop until the output side has caught up.
   task automatic run_phase(input int quota);
      int      sent;
      int      burst;
      req_type noise;
      sent = 0;
      while (sent < quota) begin
         calm = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 99) < 15) begin
            noise.cmd = 1'($urandom_range(0, 1));
            noise.key = KEY_W'($urandom_range(0, 15));
            noise.pins = PIN_W'($urandom_range(0, 511));
            feed(noise);
            sent++;
         end else begin
            gesture_burst(burst);
            sent += burst;
         end
         if ($urandom_range(0, 29) == 0) wait_idle();
      end
      calm = 1'b0;
      wait_idle();
   endtask

   // Output side: random stalls, skipped during calm stretches.
   initial begin : rsp_pacer
      int len;
      forever begin
         len = calm ? 0 : pause_len();
         if (len == 0) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            repeat (len) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   // Compare every accepted output transaction with the oldest expected gesture.
   always @(posedge clock) begin : check_gestures
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (gestures_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected gesture %0d key %0d count %0d last %0d", $time,
                        rsp_data.gesture, rsp_data.key_index, rsp_data.press_count,
                        rsp_data.last);
         end else begin
            want = gestures_due.pop_front();
            if (rsp_data.gesture !== want.gesture || rsp_data.key_index !== want.key_index ||
                rsp_data.press_count !== want.press_count || rsp_data.last !== want.last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"%0t: expected gesture %0d key %0d count %0d last %0d, ",
                            "got %0d %0d %0d %0d"},
                           $time, want.gesture, want.key_index, want.press_count, want.last,
                           rsp_data.gesture, rsp_data.key_index, rsp_data.press_count,
                           rsp_data.last);
            end
         end
      end
   end

   initial begin : stimulus
      dir_row_type dir_rows [$];
      int          pairs;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table straight from reset, with short timers: debounce 1, long 3,
      // repeat 1, window 2, multi key 4.
      apply_settings(16'd1, 16'd3, 16'd1, 16'd2, 16'd4);
      // Ordinary key: clicks while held, then a long press and a release.
      dir_rows.push_back('{key_tick(9'h1FF), 1'b1, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_edge(4'd2, 9'h000), 1'b1, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1FB), 1'b1, 2'd1,
                           make_gesture(G_CLICK, 4'd2, 8'd0, 1'b1), NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1FB), 1'b1, 2'd1,
                           make_gesture(G_CLICK, 4'd2, 8'd0, 1'b1), NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1FB), 1'b1, 2'd1,
                           make_gesture(G_LONG, 4'd2, 8'd0, 1'b1), NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1FF), 1'b1, 2'd1,
                           make_gesture(G_RELEASE, 4'd2, 8'd0, 1'b1), NO_RESULT});
      // An edge on a key that does not exist arms nothing.
      dir_rows.push_back('{key_edge(4'd15, 9'h1FF), 1'b1, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_tick(9'h000), 1'b1, 2'd0, NO_RESULT, NO_RESULT});
      // Highest key.
      dir_rows.push_back('{key_edge(4'd8, 9'h1FF), 1'b1, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_tick(9'h0FF), 1'b1, 2'd1,
                           make_gesture(G_CLICK, 4'd8, 8'd0, 1'b1), NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1FF), 1'b1, 2'd1,
                           make_gesture(G_RELEASE, 4'd8, 8'd0, 1'b1), NO_RESULT});
      // Two releases of the multi key inside the window give a double click.
      dir_rows.push_back('{key_edge(4'd4, 9'h000), 1'b0, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1FF), 1'b0, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_edge(4'd4, 9'h000), 1'b0, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1FF), 1'b0, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1FF), 1'b0, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1FF), 1'b0, 2'd0, NO_RESULT, NO_RESULT});
      // Multi key held: silent until the long time runs out, then long and release.
      dir_rows.push_back('{key_edge(4'd4, 9'h1FF), 1'b1, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1EF), 1'b1, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1EF), 1'b1, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1EF), 1'b1, 2'd1,
                           make_gesture(G_LONG, 4'd4, 8'd0, 1'b1), NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1FF), 1'b1, 2'd1,
                           make_gesture(G_RELEASE, 4'd4, 8'd0, 1'b1), NO_RESULT});
      // Window expiry and a key sample on the same tick give two gestures.
      dir_rows.push_back('{key_edge(4'd4, 9'h000), 1'b0, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1FF), 1'b0, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1FF), 1'b0, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_edge(4'd0, 9'h1FF), 1'b1, 2'd0, NO_RESULT, NO_RESULT});
      dir_rows.push_back('{key_tick(9'h1FE), 1'b1, 2'd2,
                           make_gesture(G_CLICK, 4'd4, 8'd1, 1'b0),
                           make_gesture(G_CLICK, 4'd0, 8'd0, 1'b1)});
      foreach (dir_rows[i])
         feed(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].n_rsp,
              dir_rows[i].first, dir_rows[i].second);
      wait_idle();

      // A little traffic on the reset values of the registers.
      apply_settings(DEF_DEBOUNCE, DEF_LONG, DEF_REPEAT, DEF_DOUBLE, CSR_W'(DEF_MULTI));
      run_phase(15);

      // Short timers.
      apply_settings(16'd1, 16'd8, 16'd2, 16'd4, 16'd4);
      run_phase(40);
      // Zero periods expire on the next tick; a zero long time makes every hold long.
      apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_phase(30);
      // Long time and window at their top: nothing turns long and the window stays open.
      apply_settings(16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'd8);
      run_phase(25);
      // Sampling never comes within the phase; the multi key is out of range.
      apply_settings(16'hFFFF, 16'd20, 16'hFFFF, 16'd5, 16'hFFFF);
      run_phase(15);
      // Upper data bits of the multi key write are dropped; key 12 does not exist.
      apply_settings(16'd3, 16'd20, 16'd3, 16'd6, 16'hFFFC);
      run_phase(30);

      // Release counter wrap: 256 releases in one window report a click with count zero.
      apply_settings(16'd1, 16'hFFFF, 16'd1, 16'd2, CSR_W'(WRAP_KEY));
      calm = 1'b1;
      pairs = 0;
      do begin
         feed(key_edge(WRAP_KEY, PIN_W'($urandom_range(0, 511))));
         feed(held_tick(WRAP_KEY, 1'b1));
         pairs++;
      end while (pairs < 2 || release_tally[WRAP_KEY] != 0);
      feed(held_tick(WRAP_KEY, 1'b1));
      feed(held_tick(WRAP_KEY, 1'b1));
      calm = 1'b0;
      wait_idle();

      // Random small settings.
      repeat (3) begin
         apply_settings(CSR_W'($urandom_range(0, 6)), CSR_W'($urandom_range(0, 40)),
                        CSR_W'($urandom_range(0, 6)), CSR_W'($urandom_range(0, 12)),
                        CSR_W'($urandom_range(0, 65535)));
         run_phase(15);
      end

      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Hard stop if the run hangs.
   initial begin : watchdog
      #(TIMEOUT_CYCLES * PERIOD_NS);
      $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/kgc_pkg.sv
hdl/kgc_engine.sv
hdl/kgc_rsp_buf.sv
hdl/key_gesture_classifier.sv
verif/tb.sv
